// ===== hdl/dmm_pkg.sv =====
// ---------------------------------------------------------------------------
// dmm_pkg: shared types and constants
// Beat formats, command codes, sequencer states and the pipeline tag of the
// dense matrix multiplier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmm_pkg;

  localparam int IDX_W    = 4;
  localparam int SIZE_W   = 5;
  localparam int IN_ELEM_W = 16;
  localparam int RESULT_W = 40;
  localparam int MAX_SIZE = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_ROW    = 2'd2;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic [IDX_W-1:0]            row_index;
    logic [IDX_W-1:0]            col_index;
    logic signed [IN_ELEM_W-1:0] element_value;
  } dmm_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]           out_col;
    logic signed [RESULT_W-1:0] product_value;
    logic                       last_of_row;
  } dmm_out_t;

  // travels with each operand pair down the MAC pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             col_last;
    logic [IDX_W-1:0] col;
  } dmm_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_ISSUE
  } dmm_state_t;

endpackage

`default_nettype wire

// ===== hdl/dmm_store.sv =====
// ---------------------------------------------------------------------------
// dmm_store: element stores for A and B
// Two row-major memories with one write port and one registered read port
// each. A is read along a row, B down a column.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmm_store
  import dmm_pkg::*;
#(
  parameter int DIM       = 16,
  parameter int ELEM_BITS = 16
) (
  input  wire                         clk,
  input  wire                         wr_en_a,
  input  wire                         wr_en_b,
  input  wire [IDX_W-1:0]             wr_row,
  input  wire [IDX_W-1:0]             wr_col,
  input  wire signed [ELEM_BITS-1:0]  wr_data,
  input  wire [IDX_W-1:0]             rd_row,
  input  wire [IDX_W-1:0]             rd_k,
  input  wire [IDX_W-1:0]             rd_col,
  output logic signed [ELEM_BITS-1:0] rd_a,
  output logic signed [ELEM_BITS-1:0] rd_b
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);

  logic signed [ELEM_BITS-1:0] mem_a [DEPTH];
  logic signed [ELEM_BITS-1:0] mem_b [DEPTH];

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    return AW'(AW'(r) * AW'(DIM) + AW'(c));
  endfunction

  assign wr_addr   = addr_of(wr_row, wr_col);
  assign rd_addr_a = addr_of(rd_row, rd_k);
  assign rd_addr_b = addr_of(rd_k, rd_col);

  always_ff @(posedge clk) begin
    if (wr_en_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_en_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b <= mem_b[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== hdl/dmm_mac.sv =====
// ---------------------------------------------------------------------------
// dmm_mac: shared multiply-accumulate unit
// Registers one signed product per cycle and folds it into a 40-bit
// accumulator; the last term of a column presents the finished result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmm_mac
  import dmm_pkg::*;
#(
  parameter int ELEM_BITS = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire dmm_tag_t              tag_in,
  input  wire signed [ELEM_BITS-1:0] op_a,
  input  wire signed [ELEM_BITS-1:0] op_b,
  output logic                       res_valid,
  output dmm_out_t                   res,
  output logic                       busy
);

  localparam int PW = 2 * ELEM_BITS;
  localparam int XW = (PW > RESULT_W) ? PW : RESULT_W;

  dmm_tag_t                   tag_r;
  logic signed [PW-1:0]       prod_r;
  logic signed [RESULT_W-1:0] acc_r;
  logic signed [RESULT_W-1:0] acc_nxt;
  logic signed [XW-1:0]       prod_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // wrap the product to the result width when the parameters make it wider
  assign prod_x  = XW'(prod_r);
  assign acc_nxt = (tag_r.first ? '0 : acc_r) + RESULT_W'(prod_x);

  always_ff @(posedge clk) begin
    if (tag_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign res_valid         = tag_r.valid && tag_r.last;
  assign res.out_col       = tag_r.col;
  assign res.product_value = acc_nxt;
  assign res.last_of_row   = tag_r.col_last;
  assign busy              = tag_r.valid;

endmodule

`default_nettype wire

// ===== hdl/dense_matrix_multiply.sv =====
// ---------------------------------------------------------------------------
// dense_matrix_multiply: square matrix product, one row of C per query
// Loads single elements of A and B, then streams a requested row of C
// through one shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
//   port group | direction | beat
//   in_*       | input     | dmm_in_t: load A, load B or row query
//   out_*      | output    | dmm_out_t: one element of C, last flagged
//   cfg_*      | input     | active size, written with cfg_we
//
// A row query with active size n runs column by column: each column
// issues n operand pairs to the single MAC, then drains through the store
// read and product registers into the output register.
// The output register is refilled only after its beat was taken, so
// out_stall lengthens a query while it is held. in_stall is high
// from query accept until the last column has been issued.
// Reset is synchronous, active low; the stores are not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dense_matrix_multiply
  import dmm_pkg::*;
#(
  parameter int DIM       = 16,
  parameter int ELEM_BITS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire dmm_in_t      in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output dmm_out_t          out_data,
  input  wire               cfg_we,
  input  wire [SIZE_W-1:0]  cfg_wdata
);

  localparam int LIM = (DIM < MAX_SIZE) ? DIM : MAX_SIZE;

  dmm_state_t        state_r, state_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic [SIZE_W-1:0] n_eff;
  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  dmm_tag_t          s1_tag_r;
  dmm_tag_t          issue_tag;
  logic              out_valid_r;
  dmm_out_t          out_data_r;

  logic              in_accept;
  logic              idx_ok;
  logic              wr_en_a, wr_en_b;
  logic              start_query;
  logic              k_last, j_last;
  logic              pipe_empty;

  logic signed [IN_ELEM_W-1:0] in_elem;
  logic signed [ELEM_BITS-1:0] wr_elem;
  logic signed [ELEM_BITS-1:0] rd_a, rd_b;

  logic     mac_res_valid;
  dmm_out_t mac_res;
  logic     mac_busy;

  // active size: zero counts as one, capped by the store and index reach
  always_comb begin
    if (size_r == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_r > SIZE_W'(LIM)) begin
      n_eff = SIZE_W'(LIM);
    end else begin
      n_eff = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign idx_ok    = ({1'b0, in_data.row_index} < n_eff) &&
                     ({1'b0, in_data.col_index} < n_eff);
  assign in_elem   = in_data.element_value;
  assign wr_elem   = ELEM_BITS'(in_elem);

  always_comb begin
    wr_en_a     = 1'b0;
    wr_en_b     = 1'b0;
    start_query = 1'b0;
    unique case (in_data.cmd)
      CMD_LOAD_A: wr_en_a = in_accept && idx_ok;
      CMD_LOAD_B: wr_en_b = in_accept && idx_ok;
      CMD_ROW:    start_query = in_accept && ({1'b0, in_data.row_index} < n_eff);
      default:    ;
    endcase
  end

  assign k_last     = ({1'b0, k_r} == n_r - SIZE_W'(1));
  assign j_last     = ({1'b0, j_r} == n_r - SIZE_W'(1));
  assign pipe_empty = !s1_tag_r.valid && !mac_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    row_r <= row_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    row_nxt   = row_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_query) begin
          n_nxt     = n_eff;
          row_nxt   = in_data.row_index;
          j_nxt     = '0;
          state_nxt = ST_WAIT;
        end
      end
      // hold until the previous column has left the pipe and its beat is taken
      ST_WAIT: begin
        if (pipe_empty && !out_valid_r) begin
          k_nxt     = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        k_nxt = k_r + IDX_W'(1);
        if (k_last) begin
          if (j_last) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = ST_WAIT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign issue_tag.valid    = (state_r == ST_ISSUE);
  assign issue_tag.first    = (k_r == '0);
  assign issue_tag.last     = k_last;
  assign issue_tag.col_last = j_last;
  assign issue_tag.col      = j_r;

  // tag follows the store's read latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
    end else begin
      s1_tag_r <= issue_tag;
    end
  end

  dmm_store #(
    .DIM       (DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en_a (wr_en_a),
    .wr_en_b (wr_en_b),
    .wr_row  (in_data.row_index),
    .wr_col  (in_data.col_index),
    .wr_data (wr_elem),
    .rd_row  (row_r),
    .rd_k    (k_r),
    .rd_col  (j_r),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

  dmm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (s1_tag_r),
    .op_a      (rd_a),
    .op_b      (rd_b),
    .res_valid (mac_res_valid),
    .res       (mac_res),
    .busy      (mac_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mac_res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_res_valid) begin
      out_data_r <= mac_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
